// ===== design/tcot_pkg.sv =====
// Package: shared types, codes and constants of the clock offset tracker.
`timescale 1ns / 1ps

package tcot_pkg;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned BOOT_W   = 32;
    localparam int unsigned RTT_W    = 32;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned PROD_W   = 52;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [RTT_W-1:0]   MAX_RTT_RESET = 32'd50000000;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 3'd3;
    localparam logic [19:0]        MS_TO_NS      = 20'd1000000;

    localparam logic [TIME_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [TIME_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

    // input kinds
    localparam logic [1:0] KIND_SYNC    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_STAMP   = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // result kinds
    localparam logic [2:0] RK_REPLY    = 3'd0;
    localparam logic [2:0] RK_REQUEST  = 3'd1;
    localparam logic [2:0] RK_REJECTED = 3'd2;
    localparam logic [2:0] RK_LOCKED   = 3'd3;
    localparam logic [2:0] RK_UPDATED  = 3'd4;
    localparam logic [2:0] RK_STAMP    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RTT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 2'd1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] remote_tc1;
        logic [TIME_W-1:0] remote_ts1;
        logic [TIME_W-1:0] host_now_ns;
        logic [BOOT_W-1:0] boot_ms;
    } t_item;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [TIME_W-1:0] msg_tc1;
        logic [TIME_W-1:0] msg_ts1;
        logic [TIME_W-1:0] stamp_ns;
        logic              stamp_synced;
        logic [TIME_W-1:0] offset_out_ns;
        logic [TIME_W-1:0] round_trip_ns;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic              sync_valid;
        logic [TIME_W-1:0] offset_est;
    } t_state;

endpackage

// ===== design/tcot_calc.sv =====
// Datapath: per-item offset filter, message builder and stamp conversion.
`timescale 1ns / 1ps

module tcot_calc (
    input  tcot_pkg::t_item                 i_item,
    input  tcot_pkg::t_state                i_state,
    input  logic [tcot_pkg::RTT_W-1:0]      i_max_rtt,
    input  logic [tcot_pkg::SHIFT_W-1:0]    i_shift,
    output tcot_pkg::t_result               o_result,
    output tcot_pkg::t_state                o_state
);

    logic [64:0] rtt_w;
    logic        rtt_bad;
    logic [64:0] sum_w;
    logic [64:0] sum_adj;
    logic [63:0] avg;
    logic [64:0] smp_w;
    logic [63:0] sample;
    logic [64:0] err_w;
    logic [64:0] mag_w;
    logic [63:0] step;
    logic [63:0] upd;
    logic [tcot_pkg::PROD_W-1:0] prod;
    logic [64:0] st_w;
    logic [63:0] off;

    assign off = i_state.offset_est;

    assign rtt_w   = {i_item.host_now_ns[63], i_item.host_now_ns}
                   - {i_item.remote_ts1[63], i_item.remote_ts1};
    assign rtt_bad = rtt_w[64] || (rtt_w[63:32] != 32'd0) || (rtt_w[31:0] > i_max_rtt);

    // halve the exact sum toward zero
    assign sum_w   = {i_item.remote_ts1[63], i_item.remote_ts1}
                   + {i_item.host_now_ns[63], i_item.host_now_ns};
    assign sum_adj = sum_w + {64'd0, sum_w[64]};
    assign avg     = sum_adj[64:1];

    assign smp_w  = {avg[63], avg} - {i_item.remote_tc1[63], i_item.remote_tc1};
    assign sample = (smp_w[64] != smp_w[63]) ?
                    (smp_w[64] ? tcot_pkg::S64_MIN : tcot_pkg::S64_MAX) : smp_w[63:0];

    assign err_w = {sample[63], sample} - {off[63], off};
    assign mag_w = err_w[64] ? (~err_w + 65'd1) : err_w;
    assign step  = mag_w[63:0] >> i_shift;
    assign upd   = err_w[64] ? (off - step) : (off + step);

    assign prod = tcot_pkg::PROD_W'(i_item.boot_ms) * tcot_pkg::PROD_W'(tcot_pkg::MS_TO_NS);
    assign st_w = {13'd0, prod} + {off[63], off};

    always_comb begin
        o_state              = i_state;
        o_state.valid        = 1'b1;
        o_result             = '0;
        o_result.result_kind = tcot_pkg::RK_REPLY;
        unique case (i_item.kind)
            tcot_pkg::KIND_SYNC: begin
                if (i_item.remote_tc1 == 64'd0) begin
                    o_result.result_kind = tcot_pkg::RK_REPLY;
                    o_result.msg_tc1     = i_item.host_now_ns;
                    o_result.msg_ts1     = i_item.remote_ts1;
                end else begin
                    o_result.round_trip_ns = rtt_w[63:0];
                    if (rtt_bad) begin
                        o_result.result_kind = tcot_pkg::RK_REJECTED;
                    end else if (!i_state.sync_valid) begin
                        o_result.result_kind = tcot_pkg::RK_LOCKED;
                        o_state.offset_est   = sample;
                        o_state.sync_valid   = 1'b1;
                    end else begin
                        o_result.result_kind = tcot_pkg::RK_UPDATED;
                        o_state.offset_est   = upd;
                    end
                end
            end
            tcot_pkg::KIND_REQUEST: begin
                o_result.result_kind = tcot_pkg::RK_REQUEST;
                o_result.msg_ts1     = i_item.host_now_ns;
            end
            tcot_pkg::KIND_STAMP: begin
                o_result.result_kind = tcot_pkg::RK_STAMP;
                o_result.stamp_ns    = i_item.host_now_ns;
                if (i_item.boot_ms != '0 && i_state.sync_valid) begin
                    if (!st_w[64] && st_w[63]) begin
                        o_result.stamp_ns     = tcot_pkg::S64_MAX;
                        o_result.stamp_synced = 1'b1;
                    end else if (!st_w[64] && st_w[63:0] != 64'd0) begin
                        o_result.stamp_ns     = st_w[63:0];
                        o_result.stamp_synced = 1'b1;
                    end
                end
            end
            tcot_pkg::KIND_UNUSED: begin
                o_state.valid = 1'b0;
            end
            default: begin
                o_state.valid = 1'b0;
            end
        endcase
        o_result.offset_out_ns = o_state.offset_est;
    end

endmodule

// ===== design/two_way_clock_offset_tracker_core.sv =====
// Two-way clock offset tracker: input register, datapath, result register.
// Each item is held in the input register, then its result in the result register.
// One item per cycle unless the master stalls; the next item sees each offset update.
// An unused kind is taken and produces no result. Config port is always ready.
// Reset (sync, active low): offset 0, not locked, max round trip 50000000 ns,
// smoothing shift 3, both pipeline stages empty.
`timescale 1ns / 1ps

module two_way_clock_offset_tracker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // tdata: remote_tc1[63:0], remote_ts1[127:64], host_now_ns[191:128], boot_ms[223:192]
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [223:0]  s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: msg_tc1[63:0], msg_ts1[127:64], stamp_ns[191:128], stamp_synced[192],
    //        offset_out_ns[256:193], round_trip_ns[320:257], zero pad[327:321]
    output logic [327:0]  m_axis_tdata,
    // tuser: result_kind[2:0]
    output logic [2:0]    m_axis_tuser,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [tcot_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcot_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic                          r_in_valid;
    tcot_pkg::t_item               r_in;
    logic                          r_out_valid;
    tcot_pkg::t_result             r_out;
    logic                          r_sync_valid;
    logic [63:0]                   r_offset;
    logic [tcot_pkg::RTT_W-1:0]    r_max_rtt;
    logic [tcot_pkg::SHIFT_W-1:0]  r_shift;

    logic                          advance;
    tcot_pkg::t_state              cur_state;
    tcot_pkg::t_state              n_state;
    tcot_pkg::t_result             n_result;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign cur_state.valid      = r_in_valid;
    assign cur_state.sync_valid = r_sync_valid;
    assign cur_state.offset_est = r_offset;

    tcot_calc u_calc (
        .i_item    (r_in),
        .i_state   (cur_state),
        .i_max_rtt (r_max_rtt),
        .i_shift   (r_shift),
        .o_result  (n_result),
        .o_state   (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sync_valid <= 1'b0;
            r_offset     <= '0;
            r_max_rtt    <= tcot_pkg::MAX_RTT_RESET;
            r_shift      <= tcot_pkg::SHIFT_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && n_state.valid;
                if (r_in_valid && n_state.valid) begin
                    r_sync_valid <= n_state.sync_valid;
                    r_offset     <= n_state.offset_est;
                end
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == tcot_pkg::REG_MAX_RTT) begin
                    r_max_rtt <= i_cfg_data;
                end else if (i_cfg_index == tcot_pkg::REG_SHIFT) begin
                    r_shift <= i_cfg_data[tcot_pkg::SHIFT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.kind        <= s_axis_tuser;
            r_in.remote_tc1  <= s_axis_tdata[63:0];
            r_in.remote_ts1  <= s_axis_tdata[127:64];
            r_in.host_now_ns <= s_axis_tdata[191:128];
            r_in.boot_ms     <= s_axis_tdata[223:192];
        end
        if (advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tdata  = {7'd0, r_out.round_trip_ns, r_out.offset_out_ns,
                            r_out.stamp_synced, r_out.stamp_ns, r_out.msg_ts1,
                            r_out.msg_tc1};

endmodule

// ===== tb/tcot_checker.sv =====
// Checker: tracks the offset estimate from observed transfers and compares every result.
`timescale 1ns / 1ps

module tcot_checker
    import tcot_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [223:0]         i_s_tdata,   // remote_tc1, remote_ts1, host_now_ns, boot_ms
    input  logic [1:0]           i_s_tuser,   // kind
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // msg_tc1, msg_ts1, stamp_ns, stamp_synced, offset_out_ns, round_trip_ns, zero pad
    input  logic [327:0]         i_m_tdata,
    input  logic [2:0]           i_m_tuser,   // result_kind
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [RTT_W-1:0]   max_rtt;
    logic [SHIFT_W-1:0] shift;
    logic [TIME_W-1:0]  offset;
    logic               locked;
    t_result            tracker_out_q[$];
    int                 mismatches = 0;

    // Returns 1 and the expected result when the item produces one.
    function automatic bit advance_tracker(input t_item itm, output t_result res);
        logic signed [65:0] now_w, ts1_w, tc1_w, off_w, lim_w, diff_w, smp_w, err_w, sum_w;
        logic [65:0]        mag, prod;
        logic [63:0]        smp, step;
        res   = '0;
        now_w = $signed(itm.host_now_ns);
        ts1_w = $signed(itm.remote_ts1);
        tc1_w = $signed(itm.remote_tc1);
        off_w = $signed(offset);
        lim_w = {34'd0, max_rtt};
        if (itm.kind == KIND_UNUSED)
            return 1'b0;
        case (itm.kind)
            KIND_SYNC: begin
                if (itm.remote_tc1 == '0) begin
                    res.result_kind = RK_REPLY;
                    res.msg_tc1     = itm.host_now_ns;
                    res.msg_ts1     = itm.remote_ts1;
                end else begin
                    res.round_trip_ns = itm.host_now_ns - itm.remote_ts1;
                    diff_w = now_w - ts1_w;
                    if (diff_w[65] || diff_w > lim_w) begin
                        res.result_kind = RK_REJECTED;
                    end else begin
                        // midpoint truncates toward zero, then saturate to 64 bits
                        smp_w = (ts1_w + now_w) / 66'sd2 - tc1_w;
                        if (smp_w[65:63] == 3'b000 || smp_w[65:63] == 3'b111)
                            smp = smp_w[63:0];
                        else
                            smp = smp_w[65] ? S64_MIN : S64_MAX;
                        if (!locked) begin
                            offset          = smp;
                            locked          = 1'b1;
                            res.result_kind = RK_LOCKED;
                        end else begin
                            err_w  = $signed(smp) - off_w;
                            mag    = err_w[65] ? -err_w : err_w;
                            step   = mag[63:0] >> shift;
                            offset = err_w[65] ? offset - step : offset + step;
                            res.result_kind = RK_UPDATED;
                        end
                    end
                end
            end
            KIND_REQUEST: begin
                res.result_kind = RK_REQUEST;
                res.msg_ts1     = itm.host_now_ns;
            end
            default: begin
                res.result_kind = RK_STAMP;
                res.stamp_ns    = itm.host_now_ns;
                if (itm.boot_ms != '0 && locked) begin
                    prod  = {34'd0, itm.boot_ms} * {46'd0, MS_TO_NS};
                    sum_w = $signed(prod) + off_w;
                    if (!sum_w[65] && sum_w[64:63] != 2'b00)
                        sum_w = {2'b00, S64_MAX};
                    if (!sum_w[65] && sum_w != 66'sd0) begin
                        res.stamp_ns     = sum_w[63:0];
                        res.stamp_synced = 1'b1;
                    end
                end
            end
        endcase
        res.offset_out_ns = offset;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   itm;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            max_rtt = MAX_RTT_RESET;
            shift   = SHIFT_RESET;
            offset  = '0;
            locked  = 1'b0;
            tracker_out_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_RTT: max_rtt = i_cfg_data;
                    REG_SHIFT:   shift   = i_cfg_data[SHIFT_W-1:0];
                    default:     ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                itm.kind        = i_s_tuser;
                itm.remote_tc1  = i_s_tdata[63:0];
                itm.remote_ts1  = i_s_tdata[127:64];
                itm.host_now_ns = i_s_tdata[191:128];
                itm.boot_ms     = i_s_tdata[223:192];
                if (advance_tracker(itm, want))
                    tracker_out_q.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.result_kind   = i_m_tuser;
                got.msg_tc1       = i_m_tdata[63:0];
                got.msg_ts1       = i_m_tdata[127:64];
                got.stamp_ns      = i_m_tdata[191:128];
                got.stamp_synced  = i_m_tdata[192];
                got.offset_out_ns = i_m_tdata[256:193];
                got.round_trip_ns = i_m_tdata[320:257];
                if (tracker_out_q.size() == 0) begin
                    $error("result transfer with nothing pending, result_kind %0d", got.result_kind);
                    mismatches++;
                end else begin
                    want = tracker_out_q.pop_front();
                    check_field("result_kind", want.result_kind, got.result_kind);
                    check_field("msg_tc1", want.msg_tc1, got.msg_tc1);
                    check_field("msg_ts1", want.msg_ts1, got.msg_ts1);
                    check_field("stamp_ns", want.stamp_ns, got.stamp_ns);
                    check_field("stamp_synced", want.stamp_synced, got.stamp_synced);
                    check_field("offset_out_ns", want.offset_out_ns, got.offset_out_ns);
                    check_field("round_trip_ns", want.round_trip_ns, got.round_trip_ns);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= tracker_out_q.size();
    end

endmodule

// ===== tb/two_way_clock_offset_tracker_core_tb.sv =====
// Testbench top: directed and random stimulus for the clock offset tracker, and the verdict.
`timescale 1ns / 1ps

module two_way_clock_offset_tracker_core_tb;

    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 100;

    // indexes past the register list, written to check they are ignored
    localparam logic [tcot_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [tcot_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [223:0]                   s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [327:0]                   m_axis_tdata;
    logic [2:0]                     m_axis_tuser;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tcot_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tcot_pkg::CFG_DAT_W-1:0] i_cfg_data;

    int          fail_count;
    int          pending;
    bit          tx_stall;
    bit          rx_stall;
    bit          rx_hold;
    bit          hold_done;
    logic [31:0] cur_max_rtt;
    logic [63:0] offset_target;

    two_way_clock_offset_tracker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tcot_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (rx_stall && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    function automatic tcot_pkg::t_item mk_item(input logic [1:0] kind,
                                                input logic [63:0] tc1,
                                                input logic [63:0] ts1,
                                                input logic [63:0] now,
                                                input logic [31:0] boot);
        tcot_pkg::t_item itm;
        itm.kind        = kind;
        itm.remote_tc1  = tc1;
        itm.remote_ts1  = ts1;
        itm.host_now_ns = now;
        itm.boot_ms     = boot;
        return itm;
    endfunction

    // Mostly well-formed exchanges whose samples sit near target, plus noise.
    function automatic tcot_pkg::t_item rand_item(input logic [31:0] lim,
                                                  input logic [63:0] target);
        tcot_pkg::t_item itm;
        int              pick;
        logic [63:0]     rtt;
        pick            = $urandom_range(0, 99);
        itm.kind        = tcot_pkg::KIND_SYNC;
        itm.host_now_ns = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} : {$urandom, $urandom};
        itm.remote_ts1  = {$urandom, $urandom};
        itm.remote_tc1  = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       itm.boot_ms = '0;
            1:       itm.boot_ms = $urandom_range(1, 1000);
            default: itm.boot_ms = $urandom;
        endcase
        if (pick < 6) begin
            itm.kind = tcot_pkg::KIND_UNUSED;
        end else if (pick < 18) begin
            itm.kind = tcot_pkg::KIND_REQUEST;
        end else if (pick < 45) begin
            itm.kind = tcot_pkg::KIND_STAMP;
        end else if (pick < 52) begin
            itm.remote_tc1 = '0;
        end else begin
            case ($urandom_range(0, 9))
                7:       rtt = {32'd0, lim} + 64'd1 + $urandom_range(0, 1000);
                8:       rtt = -64'd1 - $urandom_range(0, 1000);
                9:       rtt = {$urandom, $urandom};
                default: rtt = ($urandom_range(0, 3) == 0) ? {32'd0, lim}
                                                           : {32'd0, $urandom_range(0, lim)};
            endcase
            itm.remote_ts1 = itm.host_now_ns - rtt;
            if ($urandom_range(0, 7) != 0)
                itm.remote_tc1 = itm.host_now_ns - (rtt >> 1) - target
                                 + $urandom_range(0, 2000) - 64'd1000;
            if (itm.remote_tc1 == '0)
                itm.remote_tc1 = 64'd1;
        end
        return itm;
    endfunction

    task automatic send_item(input tcot_pkg::t_item itm);
        if (tx_stall && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tdata  = {itm.boot_ms, itm.host_now_ns, itm.remote_ts1, itm.remote_tc1};
        s_axis_tuser  = itm.kind;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tcot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcot_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop sending, let every pending result out, then cover items with no result
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        tcot_pkg::t_item itm;
        int              sent;
        logic [2:0]      shamt;
        logic [31:0]     small_off;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        tx_stall      = 1'b1;
        rx_stall      = 1'b1;
        rx_hold       = 1'b0;
        cur_max_rtt   = tcot_pkg::MAX_RTT_RESET;
        offset_target = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: round trip limit 50 ms, shift 3
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd12345, 32'hFFFF_FFFF));
        send_item(mk_item(tcot_pkg::KIND_REQUEST, 64'd0, 64'd0, tcot_pkg::S64_MIN, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd0, tcot_pkg::S64_MIN, tcot_pkg::S64_MAX,
                          32'd7));
        send_item(mk_item(tcot_pkg::KIND_UNUSED, '1, '1, '1, '1));
        send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd5, 64'd10, 64'd9, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd7, 64'd0, 64'd50000001, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd123456789, -64'sd49999999, 64'd1, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_SYNC, -64'sd1000, -64'sd3, 64'd0, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd5, 32'd1000));
        repeat (3) send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd1, tcot_pkg::S64_MIN,
                                     tcot_pkg::S64_MIN, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd77, 32'hFFFF_FFFF));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd78, 32'd0));

        // zero round trip limit, no smoothing
        drain();
        write_reg(tcot_pkg::REG_MAX_RTT, 32'd0);
        write_reg(tcot_pkg::REG_SHIFT, 32'hFFFF_FFF8);
        send_item(mk_item(tcot_pkg::KIND_SYNC, tcot_pkg::S64_MIN, tcot_pkg::S64_MAX,
                          tcot_pkg::S64_MAX, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd3, 64'd0, 64'd1, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF));
        send_item(mk_item(tcot_pkg::KIND_SYNC, tcot_pkg::S64_MAX, tcot_pkg::S64_MIN,
                          tcot_pkg::S64_MIN, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd9, 32'd5));
        send_item(mk_item(tcot_pkg::KIND_SYNC, 64'd1000000, 64'd0, 64'd0, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd11, 32'd1));
        send_item(mk_item(tcot_pkg::KIND_STAMP, 64'd0, 64'd0, 64'd12, 32'd2));

        // widest limit, heaviest smoothing
        drain();
        write_reg(tcot_pkg::REG_MAX_RTT, 32'hFFFF_FFFF);
        write_reg(tcot_pkg::REG_SHIFT, 32'd7);
        write_reg(REG_SPARE_2, 32'd0);
        write_reg(REG_SPARE_3, 32'hFFFF_FFFF);
        send_item(mk_item(tcot_pkg::KIND_SYNC, -64'sd5, 64'd0, 64'h0000_0000_FFFF_FFFF, 32'd0));
        send_item(mk_item(tcot_pkg::KIND_SYNC, -64'sd5, -64'sd1, 64'h0000_0000_FFFF_FFFF,
                          32'd0));
        send_item(mk_item(tcot_pkg::KIND_REQUEST, 64'd0, 64'd0, tcot_pkg::S64_MAX, 32'd0));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       cur_max_rtt = 32'hFFFF_FFFF;
                2:       cur_max_rtt = tcot_pkg::MAX_RTT_RESET;
                3:       cur_max_rtt = $urandom_range(0, 1000);
                5:       cur_max_rtt = 32'd0;
                default: cur_max_rtt = $urandom;
            endcase
            write_reg(tcot_pkg::REG_MAX_RTT, cur_max_rtt);
            shamt = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd7 : 3'($urandom_range(0, 7));
            write_reg(tcot_pkg::REG_SHIFT, ($urandom & 32'hFFFF_FFF8) | {29'd0, shamt});
            if ($urandom_range(0, 1) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
            small_off     = $urandom;
            offset_target = $urandom_range(0, 1) ? {$urandom, $urandom}
                                                 : {{32{small_off[31]}}, small_off};
            tx_stall = (ph % 2 == 0) && (ph < PHASES - 1);
            rx_stall = (ph == 0 || ph == 1 || ph == 4 || ph == 5);
            if (ph == 3)
                rx_hold = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                itm = rand_item(cur_max_rtt, offset_target);
                send_item(itm);
                if (itm.kind != tcot_pkg::KIND_UNUSED)
                    sent++;
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
